[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCAA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LCAA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/lcaa_pkg.sv]
package lcaa_pkg;

   localparam int ACT_W   = 2;
   localparam int LABEL_W = 10;
   localparam int POS_W   = 20;
   localparam int SUM_W   = 60;
   localparam int AREA_W  = 40;
   localparam int CENT_W  = 24;
   localparam int ENTRY_W = 2 * SUM_W + AREA_W;

   localparam logic [ACT_W-1:0] ACT_ACC   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACC,
      S_RDLOAD,
      S_DIV,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic clr_wr;
      logic acc_wr;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic div_last;
      logic rsp_free;
   } sts_type;

endpackage

[hw/rtl/lcaa_ram.sv]
module lcaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lcaa_ctrl.sv]
module lcaa_ctrl import lcaa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [ACT_W-1:0] req_action,
   output logic             req_ready,
   input  sts_type          sts,
   output cmd_type          cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_ACC:   state_in = S_ACC;
                  ACT_READ:  state_in = S_RDLOAD;
                  ACT_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ACC:    state_in = S_IDLE;
         S_RDLOAD: state_in = S_DIV;
         S_DIV: begin
            if (sts.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clr_wr = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_ACC:    cmd.acc_wr   = 1'b1;
         S_RDLOAD: cmd.div_load = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_OUT:    cmd.out_load = sts.rsp_free;
         default:  cmd = '0;
      endcase
   end

endmodule

[hw/rtl/lcaa_dpath.sv]
module lcaa_dpath import lcaa_pkg::*; #(
   parameter int LABELS     = 1024,
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [LABEL_W-1:0] req_label,
   input  logic [POS_W-1:0]   req_pos_x,
   input  logic [POS_W-1:0]   req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LABEL_W-1:0] rsp_out_label,
   output logic               rsp_present,
   output logic [CENT_W-1:0]  rsp_centroid_x,
   output logic [CENT_W-1:0]  rsp_centroid_y,
   output logic [AREA_W-1:0]  rsp_area
);

   localparam int ADDR_W = $clog2(LABELS);
   localparam int NUM_W  = SUM_W + FRAC_BITS;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam logic [POS_W-1:0] COORD_MASK =
      (COORD_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << COORD_BITS) - 64'd1);

   logic [LABEL_W-1:0] lbl_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               lbl_ok_ff;
   logic [POS_W-1:0]   px_ff, py_ff;
   logic [ADDR_W-1:0]  sweep_ff;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wa;
   logic [ENTRY_W-1:0] ram_wd, ram_rd;

   logic [SUM_W-1:0]   old_sx, old_sy;
   logic [AREA_W-1:0]  old_area;
   logic [SUM_W:0]     add_x, add_y;
   logic [SUM_W-1:0]   new_sx, new_sy;

   logic [NUM_W-1:0]   dx_ff, dy_ff;
   logic [AREA_W-1:0]  remx_ff, remy_ff, div_area_ff;
   logic [CENT_W-1:0]  qx_ff, qy_ff;
   logic               ovx_ff, ovy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [AREA_W:0]    trial_x, trial_y;
   logic               ge_x, ge_y;

   logic               rsp_valid_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic               rsp_present_ff;
   logic [CENT_W-1:0]  rsp_cx_ff, rsp_cy_ff;
   logic [AREA_W-1:0]  rsp_area_ff;
   logic               present;

   lcaa_ram #(.WIDTH(ENTRY_W), .DEPTH(LABELS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (cmd.take),
      .rd_addr (ADDR_W'(req_label)),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         lbl_ff    <= req_label;
         addr_ff   <= ADDR_W'(req_label);
         lbl_ok_ff <= (req_label != '0) && (32'(req_label) < LABELS);
         px_ff     <= req_pos_x & COORD_MASK;
         py_ff     <= req_pos_y & COORD_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clr_wr) begin
         sweep_ff <= sts.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   assign old_area = ram_rd[AREA_W-1:0];
   assign old_sy   = ram_rd[SUM_W+AREA_W-1:AREA_W];
   assign old_sx   = ram_rd[ENTRY_W-1:SUM_W+AREA_W];
   assign add_x    = {1'b0, old_sx} + (SUM_W+1)'(px_ff);
   assign add_y    = {1'b0, old_sy} + (SUM_W+1)'(py_ff);
   assign new_sx   = add_x[SUM_W] ? {SUM_W{1'b1}} : add_x[SUM_W-1:0];
   assign new_sy   = add_y[SUM_W] ? {SUM_W{1'b1}} : add_y[SUM_W-1:0];

   always_comb begin
      ram_we = 1'b0;
      ram_wa = addr_ff;
      ram_wd = {new_sx, new_sy, old_area + 1'b1};
      if (cmd.clr_wr) begin
         ram_we = 1'b1;
         ram_wa = sweep_ff;
         ram_wd = '0;
      end else if (cmd.acc_wr) begin
         ram_we = lbl_ok_ff && (old_area != {AREA_W{1'b1}});
      end
   end

   // Restoring division, one numerator bit per cycle for both axes.
   assign trial_x = {remx_ff, dx_ff[NUM_W-1]};
   assign trial_y = {remy_ff, dy_ff[NUM_W-1]};
   assign ge_x    = trial_x >= {1'b0, div_area_ff};
   assign ge_y    = trial_y >= {1'b0, div_area_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dx_ff       <= NUM_W'(old_sx) << FRAC_BITS;
         dy_ff       <= NUM_W'(old_sy) << FRAC_BITS;
         div_area_ff <= lbl_ok_ff ? old_area : '0;
         remx_ff     <= '0;
         remy_ff     <= '0;
         qx_ff       <= '0;
         qy_ff       <= '0;
         ovx_ff      <= 1'b0;
         ovy_ff      <= 1'b0;
         cnt_ff      <= CNT_W'(NUM_W - 1);
      end else if (cmd.div_step) begin
         dx_ff   <= dx_ff << 1;
         dy_ff   <= dy_ff << 1;
         remx_ff <= ge_x ? AREA_W'(trial_x - {1'b0, div_area_ff}) : trial_x[AREA_W-1:0];
         remy_ff <= ge_y ? AREA_W'(trial_y - {1'b0, div_area_ff}) : trial_y[AREA_W-1:0];
         qx_ff   <= {qx_ff[CENT_W-2:0], ge_x};
         qy_ff   <= {qy_ff[CENT_W-2:0], ge_y};
         ovx_ff  <= ovx_ff | qx_ff[CENT_W-1];
         ovy_ff  <= ovy_ff | qy_ff[CENT_W-1];
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign present = (div_area_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_label_ff   <= lbl_ff;
         rsp_present_ff <= present;
         rsp_cx_ff      <= !present ? '0 : (ovx_ff ? {CENT_W{1'b1}} : qx_ff);
         rsp_cy_ff      <= !present ? '0 : (ovy_ff ? {CENT_W{1'b1}} : qy_ff);
         rsp_area_ff    <= div_area_ff;
      end
   end

   assign sts.sweep_last = (sweep_ff == ADDR_W'(LABELS - 1));
   assign sts.div_last   = (cnt_ff == '0);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_label  = rsp_label_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_centroid_x = rsp_cx_ff;
   assign rsp_centroid_y = rsp_cy_ff;
   assign rsp_area       = rsp_area_ff;

endmodule

[hw/rtl/label_centroid_area_accumulator.sv]
// Per-label centroid and area statistics. Every accumulate item adds its pixel
// column, row and a count of one to the table entry of its label; label 0 and
// labels at or above LABELS are background and change nothing. A read item
// returns one result with the label's centroid (sum over area, unsigned fixed
// point with FRAC_BITS fraction bits, rounded toward zero and saturated to 24
// bits) and its area, or present low with zero fields when the area is zero.
// A clear item zeroes the table. The block works on one item at a time: an
// accumulate reads the table entry as it is accepted and then writes the update,
// after which the block is idle again; a read loads the bit-serial divider, which
// produces one numerator bit per cycle, and then registers its result; a clear
// runs the table sweep that writes one entry per cycle. The same sweep runs after
// reset, so the block takes no item until the sweep is done. The result register
// lets the next item enter while a result waits to be taken.
module label_centroid_area_accumulator import lcaa_pkg::*; #(
   parameter int LABELS     = 1024,
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [LABEL_W-1:0] req_label,
   input  logic [POS_W-1:0]   req_pos_x,
   input  logic [POS_W-1:0]   req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LABEL_W-1:0] rsp_out_label,
   output logic               rsp_present,
   output logic [CENT_W-1:0]  rsp_centroid_x,
   output logic [CENT_W-1:0]  rsp_centroid_y,
   output logic [AREA_W-1:0]  rsp_area
);

   // Command and status bundles between the sequencer and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The sequencer steps through sweep, accumulate and divide phases.
   lcaa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the table memory, the divider and the result register.
   lcaa_dpath #(
      .LABELS     (LABELS),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_label      (req_label),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_label  (rsp_out_label),
      .rsp_present    (rsp_present),
      .rsp_centroid_x (rsp_centroid_x),
      .rsp_centroid_y (rsp_centroid_y),
      .rsp_area       (rsp_area)
   );

endmodule

[hw/rtl/lcaa_checker.sv]
`include "assert_macros.svh"

module lcaa_checker import lcaa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [ACT_W-1:0]   req_action,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LABEL_W-1:0] rsp_out_label,
   input logic               rsp_present,
   input logic [CENT_W-1:0]  rsp_centroid_x,
   input logic [CENT_W-1:0]  rsp_centroid_y,
   input logic [AREA_W-1:0]  rsp_area
);

   logic rsp_fields_zero;
   logic busy_item;

   assign rsp_fields_zero = (rsp_centroid_x == '0) && (rsp_centroid_y == '0) &&
                            (rsp_area == '0);
   assign busy_item = req_valid && req_ready &&
                      (req_action == ACT_ACC || req_action == ACT_READ ||
                       req_action == ACT_CLEAR);

   `LCAA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LCAA_ASSERT_IMPLY(a_absent_zero, clock, reset, rsp_valid && !rsp_present, rsp_fields_zero)
   `LCAA_ASSERT_IMPLY(a_present_area, clock, reset, rsp_valid && rsp_present, (rsp_area != '0) && (rsp_out_label != '0))
   `LCAA_ASSERT_NEXT(a_busy_after_item, clock, reset, busy_item, !req_ready)

endmodule

bind label_centroid_area_accumulator lcaa_checker u_lcaa_checker (.*);
